// File: design/cfba_pkg.sv
// ----------------------------------------------------------------------------
// cfba_pkg
// Shared types and codes for the chunked free-list block allocator.
// ----------------------------------------------------------------------------
package cfba_pkg;

  // Request kinds carried on the input tuser bit
  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_NO_MEM     = 2'd1,
    ST_BAD_HANDLE = 2'd2,
    ST_HEAD_FREE  = 2'd3
  } status_t;

  // Register indexes (word address bit 2)
  localparam logic REG_BLOCKS_PER_CHUNK = 1'b0;
  localparam logic REG_MAX_CHUNKS       = 1'b1;

  // Register reset values
  localparam logic [8:0] BPC_RESET  = 9'd256;
  localparam logic [3:0] MAXC_RESET = 4'd8;

  // Configuration handed from the register block to the sequencer
  typedef struct packed {
    logic [8:0] blocks_per_chunk;
    logic [3:0] max_chunks;
  } cfg_t;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_ACT_CHK,
    S_SCAN,
    S_FILL,
    S_POP_RD,
    S_POP_WB,
    S_FREE_CHK,
    S_RESULT
  } state_t;

endpackage

// File: design/chunked_free_list_block_allocator.sv
// ----------------------------------------------------------------------------
// chunked_free_list_block_allocator
// Fixed-size block pool over up to MAX_CHUNKS chunks with per-chunk free lists.
// ----------------------------------------------------------------------------
// Requests enter on the s_ stream: tuser selects allocate (0) or free (1),
// tdata carries the handle to free. Each request yields exactly one word on
// the m_ stream with a status and, for a good allocation, the chunk/block.
// Two registers on the APB port set blocks_per_chunk and max_chunks.
//
// One request is in flight at a time; s_tready is high only when the
// sequencer is idle, and it stays high while a result word waits.
// Steps per request, acceptance to result word loaded:
//   free:                table read, then the head check (skipped for a bad handle)
//   allocate, hit:       table read, link read, write back
//   allocate, scan:      one scan step per open chunk scanned in the chunk table
//   allocate, new chunk: a link fill sweep over blocks_per_chunk blocks; the first
//                        allocation after reset skips the active check
//   out of memory:       the active check and a scan of the open chunks, or neither when no chunk is open
// The chunk table and link memory each have one write and one registered read
// port. The next request is taken the cycle after the result word loads.
// Reset empties the pool with no clearing pass; the first allocation opens
// chunk 0. If m_tready is low, the finished result is held and the sequencer
// waits before loading the next one.
// ----------------------------------------------------------------------------
module chunked_free_list_block_allocator #(
  parameter int MAX_CHUNKS = 8,
  parameter int MAX_BLOCKS = 256
) (
  input  logic        clk,
  input  logic        rst,
  // request stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [2:0] free_chunk, [10:3] free_block
  input  logic [0:0]  s_tuser,   // [0] req_type
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [1:0] status, [4:2] out_chunk, [12:5] out_block
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import cfba_pkg::*;

  localparam int CW = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
  localparam int OW = $clog2(MAX_CHUNKS + 1);
  localparam int BW = $clog2(MAX_BLOCKS);
  localparam int LW = BW + 1;
  localparam int AW = CW + BW;
  localparam int LINK_DEPTH = MAX_CHUNKS * (2 ** BW);

  cfg_t cfg;

  state_t state, state_next;

  logic [OW-1:0] chunks_open;
  logic [CW-1:0] active;
  logic [CW-1:0] cur_chunk;
  logic [LW-1:0] cur_head;
  logic [LW-1:0] cur_cnt;
  logic [BW-1:0] req_block;
  logic [CW-1:0] scan_idx;
  logic [LW-1:0] fill_idx;
  status_t       res_status;
  logic [2:0]    res_chunk;
  logic [7:0]    res_block;

  // memories
  logic [LW-1:0]   link_mem [LINK_DEPTH];
  logic [2*LW-1:0] tbl_mem  [MAX_CHUNKS];
  logic            link_we;
  logic [AW-1:0]   link_waddr, link_raddr;
  logic [LW-1:0]   link_wdata, link_q;
  logic            tbl_we;
  logic [CW-1:0]   tbl_waddr, tbl_raddr;
  logic [2*LW-1:0] tbl_wdata, tbl_q;

  // decode helpers
  logic          accept_in, in_free, handle_ok, active_open, can_open;
  logic          scan_last, fill_last, head_match, out_free, cnt_nz;
  logic [2:0]    in_chunk;
  logic [7:0]    in_block;
  logic [LW-1:0] eff_blocks, fill_idx_inc, tbl_head, tbl_cnt, cnt_sat, new_head;
  logic [OW-1:0] eff_chunks;

  cfba_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Clamp configuration to the built sizes
  always_comb begin
    if (cfg.blocks_per_chunk == '0) begin
      eff_blocks = LW'(1);
    end else if (32'(cfg.blocks_per_chunk) > MAX_BLOCKS) begin
      eff_blocks = LW'(MAX_BLOCKS);
    end else begin
      eff_blocks = LW'(cfg.blocks_per_chunk);
    end
    if (32'(cfg.max_chunks) > MAX_CHUNKS) begin
      eff_chunks = OW'(MAX_CHUNKS);
    end else begin
      eff_chunks = OW'(cfg.max_chunks);
    end
  end

  assign accept_in    = s_tvalid && s_tready;
  assign in_free      = (s_tuser[0] == REQ_FREE);
  assign in_chunk     = s_tdata[2:0];
  assign in_block     = s_tdata[10:3];
  assign handle_ok    = (32'(in_chunk) < 32'(chunks_open)) &&
                        (32'(in_block) < 32'(eff_blocks));
  assign active_open  = 32'(active) < 32'(chunks_open);
  assign can_open     = chunks_open < eff_chunks;
  assign tbl_head     = tbl_q[2*LW-1:LW];
  assign tbl_cnt      = tbl_q[LW-1:0];
  assign cnt_nz       = tbl_cnt != '0;
  assign scan_last    = (32'(scan_idx) + 32'd1) >= 32'(chunks_open);
  assign fill_idx_inc = fill_idx + LW'(1);
  assign fill_last    = fill_idx_inc == eff_blocks;
  assign head_match   = LW'(req_block) == tbl_head;
  assign cnt_sat      = (tbl_cnt < eff_blocks) ? tbl_cnt + LW'(1) : tbl_cnt;
  // a head past the block range stays where it is
  assign new_head     = (cur_head < LW'(MAX_BLOCKS)) ? link_q : cur_head;
  assign out_free     = !m_tvalid || m_tready;

  // Link memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[link_waddr] <= link_wdata;
    end
    link_q <= link_mem[link_raddr];
  end

  // Chunk table {head, free count}: one write, one registered read
  always_ff @(posedge clk) begin
    if (tbl_we) begin
      tbl_mem[tbl_waddr] <= tbl_wdata;
    end
    tbl_q <= tbl_mem[tbl_raddr];
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept_in) begin
          if (in_free) begin
            state_next = handle_ok ? S_FREE_CHK : S_RESULT;
          end else if (active_open) begin
            state_next = S_ACT_CHK;
          end else if (chunks_open != '0) begin
            state_next = S_SCAN;
          end else begin
            state_next = can_open ? S_FILL : S_RESULT;
          end
        end
      end
      S_ACT_CHK:  state_next = cnt_nz ? S_POP_RD : S_SCAN;
      S_SCAN: begin
        if (cnt_nz) begin
          state_next = S_POP_RD;
        end else if (!scan_last) begin
          state_next = S_SCAN;
        end else begin
          state_next = can_open ? S_FILL : S_RESULT;
        end
      end
      S_FILL:     state_next = fill_last ? S_POP_RD : S_FILL;
      S_POP_RD:   state_next = S_POP_WB;
      S_POP_WB:   state_next = S_RESULT;
      S_FREE_CHK: state_next = S_RESULT;
      S_RESULT:   state_next = out_free ? S_IDLE : S_RESULT;
      default:    state_next = S_IDLE;
    endcase
  end

  // Memory controls and handshake
  always_comb begin
    s_tready   = (state == S_IDLE);
    link_we    = 1'b0;
    link_waddr = {cur_chunk, fill_idx[BW-1:0]};
    link_wdata = fill_idx_inc;
    link_raddr = {cur_chunk, cur_head[BW-1:0]};
    tbl_we     = 1'b0;
    tbl_waddr  = cur_chunk;
    tbl_wdata  = {new_head, cur_cnt - LW'(1)};
    tbl_raddr  = cur_chunk;
    case (state)
      S_IDLE:    tbl_raddr = in_free ? CW'(in_chunk) : active;
      S_ACT_CHK: tbl_raddr = '0;
      S_SCAN:    tbl_raddr = CW'(scan_idx + CW'(1));
      S_FILL:    link_we   = 1'b1;
      S_POP_WB:  tbl_we    = 1'b1;
      S_FREE_CHK: begin
        if (!head_match) begin
          link_we    = 1'b1;
          link_waddr = {cur_chunk, req_block};
          link_wdata = tbl_head;
          tbl_we     = 1'b1;
          tbl_wdata  = {LW'(req_block), cnt_sat};
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      chunks_open <= '0;
      active      <= '0;
      m_tvalid    <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_FILL && fill_last) begin
        chunks_open <= chunks_open + OW'(1);
      end
      if (state == S_POP_WB || (state == S_FREE_CHK && !head_match)) begin
        active <= cur_chunk;
      end
      // load a new word, else drop the one taken
      if (state == S_RESULT && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Working registers and result word
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept_in) begin
          cur_chunk  <= in_free ? CW'(in_chunk) :
                        ((!active_open && chunks_open == '0) ? CW'(chunks_open) : active);
          req_block  <= BW'(in_block);
          scan_idx   <= '0;
          fill_idx   <= '0;
          // direct exits from here carry these codes
          res_status <= in_free ? ST_BAD_HANDLE : ST_NO_MEM;
          res_chunk  <= '0;
          res_block  <= '0;
        end
      end
      S_ACT_CHK: begin
        cur_head <= tbl_head;
        cur_cnt  <= tbl_cnt;
      end
      S_SCAN: begin
        if (cnt_nz) begin
          cur_chunk <= scan_idx;
          cur_head  <= tbl_head;
          cur_cnt   <= tbl_cnt;
        end else if (!scan_last) begin
          scan_idx <= scan_idx + CW'(1);
        end else begin
          cur_chunk <= CW'(chunks_open);
        end
      end
      S_FILL: begin
        fill_idx <= fill_idx_inc;
        cur_head <= '0;
        cur_cnt  <= eff_blocks;
      end
      S_POP_WB: begin
        res_status <= ST_OK;
        res_chunk  <= 3'(cur_chunk);
        res_block  <= 8'(cur_head);
      end
      S_FREE_CHK: begin
        res_status <= head_match ? ST_HEAD_FREE : ST_OK;
      end
      S_RESULT: begin
        if (out_free) begin
          m_tdata <= {3'b000, res_block, res_chunk, res_status};
        end
      end
      default: ;
    endcase
  end

endmodule

// File: design/cfba_regs.sv
// ----------------------------------------------------------------------------
// cfba_regs
// APB register block: blocks_per_chunk and max_chunks.
// ----------------------------------------------------------------------------
module cfba_regs (
  input  logic          clk,
  input  logic          rst,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  output cfba_pkg::cfg_t cfg
);
  import cfba_pkg::*;

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  // Write registers on the access cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.blocks_per_chunk <= BPC_RESET;
      cfg.max_chunks       <= MAXC_RESET;
    end else if (wr_en) begin
      case (paddr[2])
        REG_BLOCKS_PER_CHUNK: cfg.blocks_per_chunk <= pwdata[8:0];
        REG_MAX_CHUNKS:       cfg.max_chunks       <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  // Return register contents on read
  always_comb begin
    case (paddr[2])
      REG_BLOCKS_PER_CHUNK: prdata = 32'(cfg.blocks_per_chunk);
      REG_MAX_CHUNKS:       prdata = 32'(cfg.max_chunks);
      default:              prdata = '0;
    endcase
  end

endmodule

// File: design/cfba_checker.sv
// ----------------------------------------------------------------------------
// cfba_checker
// Port-level checks for the chunked free-list block allocator.
// ----------------------------------------------------------------------------
module cfba_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata
);
  import cfba_pkg::*;

  // Hold a stalled result word
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result word changed while stalled");

  // Failed requests report no block
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[1:0] != ST_OK) |-> m_tdata[12:2] == '0)
    else $error("failed request carries a handle");

  // Drop the result word after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

  // One request at a time: no accept right after an accept
  a_one_inflight: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request accepted while busy");

endmodule

bind chunked_free_list_block_allocator cfba_checker u_checker (.*);

// File: test/block_pool_tracker_pkg.sv
// ----------------------------------------------------------------------------
// block_pool_tracker_pkg
// Expected-reply tracker for the chunked free-list block allocator bench.
// ----------------------------------------------------------------------------
// Keeps a shadow copy of the chunk table, the per-chunk link lists and both
// registers. Every accepted request is applied to the shadow pool, and the
// reply it should produce is queued. Reply words from the block are checked
// against the oldest queued reply, field by field.
// ----------------------------------------------------------------------------
package block_pool_tracker_pkg;
  import cfba_pkg::*;

  localparam int POOL_CHUNKS = 8;
  localparam int POOL_BLOCKS = 256;

  typedef struct packed {
    status_t    status;
    logic [2:0] chunk;
    logic [7:0] block;
  } reply_t;

  class block_pool_tracker;
    logic [8:0]  link_mem [POOL_CHUNKS*POOL_BLOCKS];
    logic [8:0]  head [POOL_CHUNKS];
    logic [8:0]  free_cnt [POOL_CHUNKS];
    int unsigned chunks_open;
    int unsigned active;
    logic [8:0]  blocks_per_chunk;
    logic [3:0]  max_chunks;
    reply_t      replies_due [$];
    // {chunk, block} of blocks handed out and not yet given back
    logic [10:0] live_handles [$];
    int unsigned mismatches;

    function new();
      chunks_open      = 0;
      active           = 0;
      blocks_per_chunk = BPC_RESET;
      max_chunks       = MAXC_RESET;
      mismatches       = 0;
    endfunction

    function void set_register(logic idx, logic [31:0] value);
      if (idx == REG_BLOCKS_PER_CHUNK) begin
        blocks_per_chunk = value[8:0];
      end else begin
        max_chunks = value[3:0];
      end
    endfunction

    // Block count in use, held to 1..POOL_BLOCKS
    function int unsigned eff_blocks();
      if (blocks_per_chunk == 0) return 1;
      if (blocks_per_chunk > POOL_BLOCKS) return POOL_BLOCKS;
      return blocks_per_chunk;
    endfunction

    function int unsigned eff_chunks();
      if (max_chunks > POOL_CHUNKS) return POOL_CHUNKS;
      return max_chunks;
    endfunction

    // Apply one accepted request to the shadow pool and queue its reply
    function void apply_request(logic kind, logic [2:0] fc, logic [7:0] fb);
      reply_t      r;
      int unsigned c;
      int unsigned i;
      int unsigned n;
      int unsigned h;
      bit          have;
      bit          found;
      r.status = ST_OK;
      r.chunk  = '0;
      r.block  = '0;
      if (kind == REQ_ALLOC) begin
        // try the active chunk, then the lowest open chunk with room
        c    = active;
        have = (c < chunks_open) && (free_cnt[c] != 0);
        for (i = 0; i < chunks_open && !have; i++) begin
          if (free_cnt[i] != 0) begin
            c    = i;
            have = 1'b1;
          end
        end
        // open a fresh chunk with links running i to i+1
        if (!have && chunks_open < eff_chunks()) begin
          c = chunks_open;
          n = eff_blocks();
          for (i = 0; i < n; i++) link_mem[c*POOL_BLOCKS + i] = 9'(i + 1);
          head[c]     = '0;
          free_cnt[c] = 9'(n);
          chunks_open++;
          have = 1'b1;
        end
        if (!have) begin
          r.status = ST_NO_MEM;
        end else begin
          // pop the head; a head past the block range stays put
          h           = head[c];
          active      = c;
          free_cnt[c] = free_cnt[c] - 9'd1;
          if (h < POOL_BLOCKS) head[c] = link_mem[c*POOL_BLOCKS + h];
          r.chunk = c[2:0];
          r.block = h[7:0];
          live_handles.push_back({r.chunk, r.block});
        end
      end else begin
        if (fc >= chunks_open || fb >= eff_blocks()) begin
          r.status = ST_BAD_HANDLE;
        end else if (fb == head[fc]) begin
          r.status = ST_HEAD_FREE;
        end else begin
          // push the block and make its chunk active; count saturates
          active                        = fc;
          link_mem[fc*POOL_BLOCKS + fb] = head[fc];
          head[fc]                      = {1'b0, fb};
          if (free_cnt[fc] < eff_blocks()) free_cnt[fc] = free_cnt[fc] + 9'd1;
          found = 1'b0;
          for (i = 0; i < live_handles.size() && !found; i++) begin
            if (live_handles[i] == {fc, fb}) begin
              live_handles.delete(i);
              found = 1'b1;
            end
          end
        end
      end
      replies_due.push_back(r);
    endfunction

    // Compare one reply word with the oldest queued reply
    function void check_reply(logic [15:0] word);
      reply_t got;
      reply_t want;
      got.status = status_t'(word[1:0]);
      got.chunk  = word[4:2];
      got.block  = word[12:5];
      if (replies_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("reply word with no request pending: status %0d chunk %0d block %0d",
                   got.status, got.chunk, got.block);
        return;
      end
      want = replies_due.pop_front();
      if (got.status != want.status || got.chunk != want.chunk ||
          got.block != want.block) begin
        mismatches++;
        if (mismatches <= 10)
          $display("reply mismatch: expected status %0d chunk %0d block %0d, got %0d %0d %0d",
                   want.status, want.chunk, want.block, got.status, got.chunk, got.block);
      end
    endfunction
  endclass

endpackage

// File: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the chunked free-list block allocator.
// ----------------------------------------------------------------------------
// Drives allocate and free requests on the request stream and checks every
// reply word against a shadow pool. A short directed run covers pool
// exhaustion, head frees, double frees and bad handles; random phases then
// run under several register settings, mostly freeing blocks that are really
// held, with some noise. Both streams idle at random; one phase runs without
// idling and one holds the reply side off long enough to stall requests.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import cfba_pkg::*;
  import block_pool_tracker_pkg::*;

  localparam int CYCLE_LIMIT     = 300000;
  localparam int IDLE_PCT        = 21;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int SETTLE_CYCLES   = 40;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata  = '0;   // [2:0] free_chunk, [10:3] free_block
  logic [0:0]  s_tuser  = '0;   // [0] req_type
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;         // [1:0] status, [4:2] out_chunk, [12:5] out_block
  logic        psel     = 1'b0;
  logic        penable  = 1'b0;
  logic        pwrite   = 1'b0;
  logic [2:0]  paddr    = '0;
  logic [31:0] pwdata   = '0;
  logic [31:0] prdata;
  logic        pready;

  bit          steady         = 1'b0;
  bit          hold_off_armed = 1'b0;
  bit          hold_off_done  = 1'b0;
  int unsigned hold_left      = 0;
  int unsigned cycle_count    = 0;

  block_pool_tracker pool;

  chunked_free_list_block_allocator i_dut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Give up on a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("chunked_free_list_block_allocator regression: fail");
      $finish;
    end
  end

  // Reply side: random stalls, one long hold-off when armed
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left != 0) begin
      m_tready  <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_off_armed && !hold_off_done) begin
      m_tready      <= 1'b0;
      hold_left     <= HOLD_OFF_CYCLES;
      hold_off_done <= 1'b1;
    end else begin
      m_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Check each reply word taken
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) pool.check_reply(m_tdata);
  end

  // One register write: setup, then access
  task automatic reg_write(input logic idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    pool.set_register(idx, value);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic write_config(input logic [8:0] bpc, input logic [3:0] maxc);
    reg_write(REG_BLOCKS_PER_CHUNK, {23'd0, bpc});
    @(posedge clk);
    reg_write(REG_MAX_CHUNKS, {28'd0, maxc});
  endtask

  // Offer one request word and hold it until taken
  task automatic offer(input logic kind, input logic [2:0] fc, input logic [7:0] fb);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {5'd0, fb, fc};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pool.apply_request(kind, fc, fb);
  endtask

  // Mostly allocations and frees of held blocks; some head frees,
  // in-range double frees and arbitrary handles
  task automatic offer_random();
    int          roll;
    int unsigned k;
    logic        kind;
    logic [2:0]  fc;
    logic [7:0]  fb;
    roll = $urandom_range(99);
    kind = REQ_ALLOC;
    fc   = 3'($urandom_range(7));
    fb   = 8'($urandom_range(255));
    if (roll >= 45) begin
      kind = REQ_FREE;
      if (roll < 82 && pool.live_handles.size() != 0) begin
        k        = $urandom_range(pool.live_handles.size() - 1);
        {fc, fb} = pool.live_handles[k];
      end else if (roll < 88 && pool.chunks_open != 0) begin
        fc = 3'($urandom_range(pool.chunks_open - 1));
        fb = pool.head[fc][7:0];
      end else if (roll < 94 && pool.chunks_open != 0) begin
        fc = 3'($urandom_range(pool.chunks_open - 1));
        fb = 8'($urandom_range(pool.eff_blocks() - 1));
      end
    end
    offer(kind, fc, fb);
  endtask

  // Stop offering and wait for every reply to come back
  task automatic drain();
    s_tvalid <= 1'b0;
    while (pool.replies_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic run_phase(input logic [8:0] bpc, input logic [3:0] maxc,
                           input int count, input bit no_idle, input bit hold_off);
    int n;
    write_config(bpc, maxc);
    steady         <= no_idle;
    hold_off_armed <= hold_off;
    for (n = 0; n < count; n++) offer_random();
    drain();
  endtask

  initial begin
    pool = new();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Two blocks, one chunk: first alloc opens chunk 0, then exhaust it
    write_config(9'd2, 4'd1);
    offer(REQ_ALLOC, 3'd0, 8'd0);
    offer(REQ_ALLOC, 3'd7, 8'd255);
    offer(REQ_ALLOC, 3'd0, 8'd0);
    // free onto an empty list, then free the head
    offer(REQ_FREE, 3'd0, 8'd0);
    offer(REQ_FREE, 3'd0, 8'd0);
    offer(REQ_FREE, 3'd0, 8'd1);
    // double free of a block below the head; count saturates
    offer(REQ_FREE, 3'd0, 8'd0);
    // bad handles: chunk not open, block out of range
    offer(REQ_FREE, 3'd7, 8'd0);
    offer(REQ_FREE, 3'd0, 8'd255);
    offer(REQ_FREE, 3'd0, 8'd2);
    offer(REQ_ALLOC, 3'd0, 8'd0);
    offer(REQ_ALLOC, 3'd0, 8'd0);
    offer(REQ_ALLOC, 3'd0, 8'd0);
    drain();

    // Raise the chunk limit: new chunks open, a free moves the active chunk
    write_config(9'd2, 4'd8);
    offer(REQ_ALLOC, 3'd0, 8'd0);
    offer(REQ_ALLOC, 3'd0, 8'd0);
    offer(REQ_ALLOC, 3'd0, 8'd0);
    offer(REQ_FREE, 3'd1, 8'd0);
    offer(REQ_ALLOC, 3'd0, 8'd0);
    offer(REQ_FREE, 3'd7, 8'd255);
    offer(REQ_FREE, 3'd2, 8'd1);
    drain();

    // Random phases over several settings
    run_phase(9'd5,   4'd3, 150, 1'b1, 1'b0);
    run_phase(9'd1,   4'd7, 150, 1'b0, 1'b1);
    run_phase(9'd16,  4'd2, 150, 1'b0, 1'b0);
    run_phase(9'd256, 4'd1, 150, 1'b0, 1'b0);
    run_phase(9'd7,   4'd5, 150, 1'b0, 1'b0);
    run_phase(9'd2,   4'd7, 100, 1'b0, 1'b0);
    run_phase(9'd256, 4'd8, 100, 1'b0, 1'b0);

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pool.mismatches == 0 && pool.replies_due.size() == 0) begin
      $display("chunked_free_list_block_allocator regression: pass");
    end else begin
      $display("chunked_free_list_block_allocator regression: fail");
    end
    $finish;
  end

endmodule

// File: filelist.f
design/cfba_pkg.sv
design/cfba_regs.sv
design/chunked_free_list_block_allocator.sv
design/cfba_checker.sv
test/block_pool_tracker_pkg.sv
test/tb_top.sv
